@@ src/dpvr_pkg.sv @@
// shared types, widths and constants of the depth pixel view reprojection unit
package dpvr_pkg;

  localparam int unsigned IMAGE_WIDTH_DEF  = 1024;
  localparam int unsigned IMAGE_HEIGHT_DEF = 768;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam int unsigned COORD_W = 10;
  localparam int unsigned DEPTH_W = 16;
  localparam int unsigned OUT_W   = 32;
  localparam int unsigned TRIG_W  = 16;
  localparam int unsigned SCALE_W = 32;
  localparam int unsigned POS_W   = 32;

  // back-projection, sized for image dimensions up to 4096
  localparam int unsigned OFF_W    = 13;
  localparam int unsigned MAG_W    = 12;
  localparam int unsigned MD_W     = MAG_W + DEPTH_W;
  localparam int unsigned PROD_W   = MD_W + SCALE_W;
  localparam int unsigned BP_SHIFT = 24;
  localparam int unsigned PR_W     = PROD_W - BP_SHIFT;
  localparam int unsigned P_W      = PR_W + 2;
  localparam int unsigned V_W      = P_W + 1;

  // rotation
  localparam int unsigned Q14_SHIFT = 14;
  localparam int unsigned Q14_HALF  = 8192;
  localparam int unsigned YP_W      = V_W + TRIG_W;
  localparam int unsigned YS_W      = YP_W + 1;
  localparam int unsigned Y_W       = YS_W - Q14_SHIFT;
  localparam int unsigned PP_W      = Y_W + TRIG_W;
  localparam int unsigned PS_W      = PP_W + 1;
  localparam int unsigned R_W       = PS_W - Q14_SHIFT;

  // projection
  localparam int unsigned PLANE_DEPTH = 1000;
  localparam int unsigned PD_W        = 10;
  localparam int unsigned M_W         = R_W + PD_W;
  localparam int unsigned DD_W        = R_W - 1;
  localparam int unsigned D_W         = DD_W + 1;
  localparam int unsigned N_W         = M_W + 1;
  localparam int unsigned QUO_W       = OUT_W - 1;
  localparam int unsigned RW          = D_W + 1;
  localparam int unsigned DIV_LAT     = QUO_W + 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LATERAL_SCALE = 3'd0,
    REG_VIEWER_X      = 3'd1,
    REG_VIEWER_Y      = 3'd2,
    REG_VIEWER_Z      = 3'd3,
    REG_YAW_SINE      = 3'd4,
    REG_YAW_COSINE    = 3'd5,
    REG_PITCH_SINE    = 3'd6,
    REG_PITCH_COSINE  = 3'd7
  } cfg_reg_e;

  localparam logic signed [TRIG_W-1:0] TRIG_ONE = 16'sd16384;

  typedef struct packed {
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row;
    logic [DEPTH_W-1:0] depth_mm;
  } pixel_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] rotated_x;
    logic signed [OUT_W-1:0] rotated_y;
    logic signed [OUT_W-1:0] rotated_z;
    logic signed [OUT_W-1:0] screen_x;
    logic signed [OUT_W-1:0] screen_y;
    logic                    behind_viewer;
  } result_t;

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [R_W-1:0] v);
    logic fits;
    fits = (&v[R_W-1:OUT_W-1]) || !(|v[R_W-1:OUT_W-1]);
    if (fits) begin
      return v[OUT_W-1:0];
    end else if (v[R_W-1]) begin
      return {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      return {1'b0, {(OUT_W-1){1'b1}}};
    end
  endfunction

endpackage

@@ src/dpvr_div.sv @@
// pipelined restoring divider for the projection, one quotient bit per stage, saturated
module dpvr_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  logic [dpvr_pkg::N_W-1:0]          num_i,
  input  logic [dpvr_pkg::D_W-1:0]          den_i,
  input  logic                              neg_i,
  output logic                              valid_o,
  output logic signed [dpvr_pkg::OUT_W-1:0] quot_o
);
  import dpvr_pkg::*;

  typedef struct packed {
    logic [RW-1:0]    rem;
    logic [QUO_W-1:0] low;
    logic [QUO_W-1:0] quo;
    logic [D_W-1:0]   den;
    logic             ovf;
    logic             neg;
  } div_stage_t;

  logic [QUO_W:0] vld_q;
  div_stage_t     stg_q [QUO_W+1];
  div_stage_t     stg_d [QUO_W+1];
  logic           out_vld_q;
  logic signed [OUT_W-1:0] quot_q;

  always_comb begin
    logic [RW-1:0] trial;
    logic          ge;
    // first stage: a quotient of 2^31 or more only saturates
    stg_d[0].rem = RW'(num_i[N_W-1:QUO_W]);
    stg_d[0].ovf = RW'(num_i[N_W-1:QUO_W]) >= RW'(den_i);
    stg_d[0].low = num_i[QUO_W-1:0];
    stg_d[0].quo = '0;
    stg_d[0].den = den_i;
    stg_d[0].neg = neg_i;
    for (int k = 1; k <= QUO_W; k++) begin
      trial    = {stg_q[k-1].rem[RW-2:0], stg_q[k-1].low[QUO_W-1]};
      ge       = trial >= {1'b0, stg_q[k-1].den};
      stg_d[k] = stg_q[k-1];
      stg_d[k].rem = ge ? trial - {1'b0, stg_q[k-1].den} : trial;
      stg_d[k].low = {stg_q[k-1].low[QUO_W-2:0], 1'b0};
      stg_d[k].quo = {stg_q[k-1].quo[QUO_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      vld_q     <= {vld_q[QUO_W-1:0], valid_i};
      out_vld_q <= vld_q[QUO_W];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k <= QUO_W; k++) begin
      stg_q[k] <= stg_d[k];
    end
    if (stg_q[QUO_W].ovf) begin
      quot_q <= stg_q[QUO_W].neg ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
    end else begin
      quot_q <= stg_q[QUO_W].neg ? -$signed({1'b0, stg_q[QUO_W].quo})
                                 : $signed({1'b0, stg_q[QUO_W].quo});
    end
  end

  assign valid_o = out_vld_q;
  assign quot_o  = quot_q;

  a_div_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(valid_i, DIV_LAT))
    else $error("divider result without a matching operand");

  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[QUO_W] && !stg_q[QUO_W].ovf |-> stg_q[QUO_W].rem < {1'b0, stg_q[QUO_W].den})
    else $error("divider remainder not below divisor");

endmodule

@@ src/depth_pixel_view_reprojection_unit.sv @@
// depth pixel view reprojection: back-projection, yaw and pitch rotation, projection to z=1000
// result strobe follows the start cycle through 10 arithmetic stages, 33 divider
//   stages for the two projection quotients and one output register
// throughput: one pixel per cycle, busy never rises
// reset clears all valid bits and sets the registers to identity rotation, zero scale and position
module depth_pixel_view_reprojection_unit #(
  parameter int unsigned IMAGE_WIDTH  = dpvr_pkg::IMAGE_WIDTH_DEF,
  parameter int unsigned IMAGE_HEIGHT = dpvr_pkg::IMAGE_HEIGHT_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  dpvr_pkg::pixel_t                 pixel_i,
  output logic                             result_valid_o,
  output dpvr_pkg::result_t                result_o,
  input  logic                             cfg_we_i,
  input  logic [dpvr_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [dpvr_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import dpvr_pkg::*;

  localparam int unsigned NSTG = 10;
  localparam logic [OFF_W-1:0] CENTER_X = OFF_W'(IMAGE_WIDTH / 2);
  localparam logic [OFF_W-1:0] CENTER_Y = OFF_W'(IMAGE_HEIGHT / 2);

  typedef struct packed {
    logic signed [OUT_W-1:0] rot_x;
    logic signed [OUT_W-1:0] rot_y;
    logic signed [OUT_W-1:0] rot_z;
    logic                    behind;
  } side_t;

  // configuration registers
  logic        [SCALE_W-1:0] scale_q;
  logic signed [POS_W-1:0]   vwx_q, vwy_q, vwz_q;
  logic signed [TRIG_W-1:0]  ysin_q, ycos_q, psin_q, pcos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= '0;
      vwx_q   <= '0;
      vwy_q   <= '0;
      vwz_q   <= '0;
      ysin_q  <= '0;
      ycos_q  <= TRIG_ONE;
      psin_q  <= '0;
      pcos_q  <= TRIG_ONE;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_LATERAL_SCALE: scale_q <= cfg_data_i;
        REG_VIEWER_X:      vwx_q   <= $signed(cfg_data_i);
        REG_VIEWER_Y:      vwy_q   <= $signed(cfg_data_i);
        REG_VIEWER_Z:      vwz_q   <= $signed(cfg_data_i);
        REG_YAW_SINE:      ysin_q  <= $signed(cfg_data_i[TRIG_W-1:0]);
        REG_YAW_COSINE:    ycos_q  <= $signed(cfg_data_i[TRIG_W-1:0]);
        REG_PITCH_SINE:    psin_q  <= $signed(cfg_data_i[TRIG_W-1:0]);
        REG_PITCH_COSINE:  pcos_q  <= $signed(cfg_data_i[TRIG_W-1:0]);
        default: ;
      endcase
    end
  end

  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  logic [NSTG-1:0] vld_q;

  // stage 1: offsets from the image centre, magnitude times depth
  logic [OFF_W-1:0] offx, offy;
  logic [MAG_W-1:0] magx, magy;
  logic [MD_W-1:0]  s1_mdx_q, s1_mdy_q;
  logic             s1_negx_q, s1_negy_q;
  logic [DEPTH_W-1:0] s1_dep_q;

  assign offx = OFF_W'(pixel_i.column) - CENTER_X;
  assign offy = OFF_W'(pixel_i.row) - CENTER_Y;
  assign magx = offx[OFF_W-1] ? MAG_W'(-offx) : MAG_W'(offx);
  assign magy = offy[OFF_W-1] ? MAG_W'(-offy) : MAG_W'(offy);

  // stage 2: times lateral scale
  logic [PROD_W-1:0]  s2_px_q, s2_py_q;
  logic               s2_negx_q, s2_negy_q;
  logic [DEPTH_W-1:0] s2_dep_q;

  // stage 3: rounded, signed world point
  logic [PROD_W-1:0]      rndx, rndy;
  logic signed [P_W-1:0]  absx, absy;
  logic signed [P_W-1:0]  s3_x_q, s3_y_q, s3_z_q;

  assign rndx = s2_px_q + PROD_W'(1 << (BP_SHIFT - 1));
  assign rndy = s2_py_q + PROD_W'(1 << (BP_SHIFT - 1));
  assign absx = $signed({2'b00, rndx[PROD_W-1:BP_SHIFT]});
  assign absy = $signed({2'b00, rndy[PROD_W-1:BP_SHIFT]});

  // stage 4: viewer relative
  logic signed [V_W-1:0] s4_x_q, s4_y_q, s4_z_q;

  // stage 5: yaw products
  logic signed [YP_W-1:0] s5_zs_q, s5_xc_q, s5_zc_q, s5_xs_q;
  logic signed [V_W-1:0]  s5_y_q;

  // stage 6: yaw sums
  logic signed [YS_W-1:0] yxs, yzs;
  logic signed [Y_W-1:0]  s6_x_q, s6_z_q;
  logic signed [V_W-1:0]  s6_y_q;

  assign yxs = YS_W'(s5_zs_q) + YS_W'(s5_xc_q) + YS_W'(Q14_HALF);
  assign yzs = YS_W'(s5_zc_q) - YS_W'(s5_xs_q) + YS_W'(Q14_HALF);

  // stage 7: pitch products
  logic signed [PP_W-1:0] s7_cy_q, s7_sz_q, s7_sy_q, s7_cz_q;
  logic signed [Y_W-1:0]  s7_x_q;

  // stage 8: pitch sums
  logic signed [PS_W-1:0] rys, rzs;
  logic signed [R_W-1:0]  s8_x_q, s8_y_q, s8_z_q;

  assign rys = PS_W'(s7_cy_q) - PS_W'(s7_sz_q) + PS_W'(Q14_HALF);
  assign rzs = PS_W'(s7_sy_q) + PS_W'(s7_cz_q) + PS_W'(Q14_HALF);

  // stage 9: magnitudes times plane depth, saturated rotated point
  logic [R_W-1:0]  abx, aby;
  logic [M_W-1:0]  s9_mx_q, s9_my_q;
  logic [DD_W-1:0] s9_d_q;
  logic            s9_nx_q, s9_ny_q;
  side_t           s9_side_q;

  assign abx = s8_x_q[R_W-1] ? R_W'(-s8_x_q) : R_W'(s8_x_q);
  assign aby = s8_y_q[R_W-1] ? R_W'(-s8_y_q) : R_W'(s8_y_q);

  // stage 10: rounding numerator 2*1000*|n| + d over 2*d
  logic [N_W-1:0] s10_nx_q, s10_ny_q;
  logic [D_W-1:0] s10_d_q;
  logic           s10_nx_neg_q, s10_ny_neg_q;
  side_t          s10_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NSTG-2:0], accept};
    end
  end

  always_ff @(posedge clk_i) begin
    s1_mdx_q  <= MD_W'(magx) * MD_W'(pixel_i.depth_mm);
    s1_mdy_q  <= MD_W'(magy) * MD_W'(pixel_i.depth_mm);
    s1_negx_q <= offx[OFF_W-1];
    s1_negy_q <= offy[OFF_W-1];
    s1_dep_q  <= pixel_i.depth_mm;

    s2_px_q   <= PROD_W'(s1_mdx_q) * PROD_W'(scale_q);
    s2_py_q   <= PROD_W'(s1_mdy_q) * PROD_W'(scale_q);
    s2_negx_q <= s1_negx_q;
    s2_negy_q <= s1_negy_q;
    s2_dep_q  <= s1_dep_q;

    // image y points up, so the row offset changes sign
    s3_x_q <= s2_negx_q ? -absx : absx;
    s3_y_q <= s2_negy_q ? absy : -absy;
    s3_z_q <= $signed({{(P_W-DEPTH_W-8){1'b0}}, s2_dep_q, 8'h00});

    s4_x_q <= V_W'(s3_x_q) - V_W'(vwx_q);
    s4_y_q <= V_W'(s3_y_q) - V_W'(vwy_q);
    s4_z_q <= V_W'(s3_z_q) - V_W'(vwz_q);

    s5_zs_q <= YP_W'(s4_z_q) * YP_W'(ysin_q);
    s5_xc_q <= YP_W'(s4_x_q) * YP_W'(ycos_q);
    s5_zc_q <= YP_W'(s4_z_q) * YP_W'(ycos_q);
    s5_xs_q <= YP_W'(s4_x_q) * YP_W'(ysin_q);
    s5_y_q  <= s4_y_q;

    s6_x_q <= $signed(yxs[YS_W-1:Q14_SHIFT]);
    s6_z_q <= $signed(yzs[YS_W-1:Q14_SHIFT]);
    s6_y_q <= s5_y_q;

    s7_cy_q <= PP_W'(s6_y_q) * PP_W'(pcos_q);
    s7_sz_q <= PP_W'(s6_z_q) * PP_W'(psin_q);
    s7_sy_q <= PP_W'(s6_y_q) * PP_W'(psin_q);
    s7_cz_q <= PP_W'(s6_z_q) * PP_W'(pcos_q);
    s7_x_q  <= s6_x_q;

    s8_x_q <= R_W'(s7_x_q);
    s8_y_q <= $signed(rys[PS_W-1:Q14_SHIFT]);
    s8_z_q <= $signed(rzs[PS_W-1:Q14_SHIFT]);

    s9_mx_q <= M_W'(abx) * M_W'(PLANE_DEPTH);
    s9_my_q <= M_W'(aby) * M_W'(PLANE_DEPTH);
    s9_d_q  <= s8_z_q[DD_W-1:0];
    s9_nx_q <= s8_x_q[R_W-1];
    s9_ny_q <= s8_y_q[R_W-1];
    s9_side_q.rot_x  <= sat_out(s8_x_q);
    s9_side_q.rot_y  <= sat_out(s8_y_q);
    s9_side_q.rot_z  <= sat_out(s8_z_q);
    s9_side_q.behind <= s8_z_q[R_W-1] || (s8_z_q == '0);

    s10_nx_q     <= {s9_mx_q, 1'b0} + N_W'(s9_d_q);
    s10_ny_q     <= {s9_my_q, 1'b0} + N_W'(s9_d_q);
    s10_d_q      <= {s9_d_q, 1'b0};
    s10_nx_neg_q <= s9_nx_q;
    s10_ny_neg_q <= s9_ny_q;
    s10_side_q   <= s9_side_q;
  end

  // projection quotients
  logic                    qx_vld, qy_vld;
  logic signed [OUT_W-1:0] qx, qy;

  dpvr_div u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld_q[NSTG-1]),
    .num_i   (s10_nx_q),
    .den_i   (s10_d_q),
    .neg_i   (s10_nx_neg_q),
    .valid_o (qx_vld),
    .quot_o  (qx)
  );

  dpvr_div u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld_q[NSTG-1]),
    .num_i   (s10_ny_q),
    .den_i   (s10_d_q),
    .neg_i   (s10_ny_neg_q),
    .valid_o (qy_vld),
    .quot_o  (qy)
  );

  // rotated point and flag wait alongside the dividers
  side_t side_q [DIV_LAT];

  always_ff @(posedge clk_i) begin
    side_q[0] <= s10_side_q;
    for (int k = 1; k < DIV_LAT; k++) begin
      side_q[k] <= side_q[k-1];
    end
  end

  logic    out_vld_q;
  result_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= qx_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q.rotated_x     <= side_q[DIV_LAT-1].rot_x;
    res_q.rotated_y     <= side_q[DIV_LAT-1].rot_y;
    res_q.rotated_z     <= side_q[DIV_LAT-1].rot_z;
    res_q.behind_viewer <= side_q[DIV_LAT-1].behind;
    res_q.screen_x      <= side_q[DIV_LAT-1].behind ? '0 : qx;
    res_q.screen_y      <= side_q[DIV_LAT-1].behind ? '0 : qy;
  end

  assign result_valid_o = out_vld_q;
  assign result_o       = res_q;

  a_div_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qx_vld == qy_vld)
    else $error("projection dividers out of step");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##(NSTG + DIV_LAT + 1) result_valid_o)
    else $error("transaction lost in pipeline");

endmodule

@@ bench/tb_depth_pixel_view_reprojection_unit.sv @@
// self-checking testbench of the depth pixel view reprojection unit
module tb_depth_pixel_view_reprojection_unit;
  import dpvr_pkg::*;

  localparam int N_RANDOM   = 1500;
  localparam int DRAIN_WAIT = 60;
  localparam int WD_LIMIT   = 4000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  pixel_t pixel_i = '0;
  logic result_valid_o;
  result_t result_o;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  depth_pixel_view_reprojection_unit uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .pixel_i(pixel_i),
    .result_valid_o(result_valid_o), .result_o(result_o),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // shadow copy of the view registers
  longint unsigned sh_scale;
  longint sh_vx, sh_vy, sh_vz, sh_ys, sh_yc, sh_ps, sh_pc;

  result_t expected_q[$];
  int n_errors, n_pixels, n_results, n_behind, n_phases, idle_cnt;
  bit typed_pending;
  result_t typed_value;
  bit typed_now;
  result_t typed_now_value;

  function automatic longint round_q14(longint v);
    return (v + 8192) >>> 14;
  endfunction

  function automatic longint unproject(longint off, longint unsigned depth);
    longint unsigned mag, r;
    mag = (off < 0) ? longint'(-off) : longint'(off);
    r = (mag * depth * sh_scale + (64'd1 << 23)) >> 24;
    return (off < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint to_plane(longint n, longint d);
    longint unsigned mag, q;
    mag = longint'((n < 0) ? -n : n) * PLANE_DEPTH;
    q = (2 * mag + longint'(d)) / (2 * longint'(d));
    return (n < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic result_t reproject(pixel_t p);
    result_t r;
    longint px, py, pz, vx, vy, vz, yx, yz, ry, rz;
    px = unproject(longint'(p.column) - IMAGE_WIDTH_DEF / 2, p.depth_mm);
    py = -unproject(longint'(p.row) - IMAGE_HEIGHT_DEF / 2, p.depth_mm);
    pz = longint'(p.depth_mm) << 8;
    vx = px - sh_vx;
    vy = py - sh_vy;
    vz = pz - sh_vz;
    yx = round_q14(vz * sh_ys + vx * sh_yc);
    yz = round_q14(vz * sh_yc - vx * sh_ys);
    ry = round_q14(sh_pc * vy - sh_ps * yz);
    rz = round_q14(sh_ps * vy + sh_pc * yz);
    r.rotated_x = clamp32(yx);
    r.rotated_y = clamp32(ry);
    r.rotated_z = clamp32(rz);
    r.behind_viewer = (rz <= 0);
    r.screen_x = r.behind_viewer ? '0 : clamp32(to_plane(yx, rz));
    r.screen_y = r.behind_viewer ? '0 : clamp32(to_plane(ry, rz));
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    n_errors++;
  endtask

  // acceptance of pixels and results, watchdog
  always @(posedge clk_i) begin
    result_t e;
    if (rst_ni) begin
      if ((start && !busy) || result_valid_o) begin
        idle_cnt <= 0;
      end else begin
        idle_cnt <= idle_cnt + 1;
      end
      if (start && !busy) begin
        expected_q.push_back(typed_now ? typed_now_value : reproject(pixel_i));
        n_pixels++;
      end
      if (result_valid_o) begin
        n_results++;
        if (result_o.behind_viewer) n_behind++;
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result", '0, '0);
        end else begin
          e = expected_q.pop_front();
          if (result_o.rotated_x !== e.rotated_x)
            report_mismatch("rotated_x", result_o.rotated_x, e.rotated_x);
          if (result_o.rotated_y !== e.rotated_y)
            report_mismatch("rotated_y", result_o.rotated_y, e.rotated_y);
          if (result_o.rotated_z !== e.rotated_z)
            report_mismatch("rotated_z", result_o.rotated_z, e.rotated_z);
          if (result_o.screen_x !== e.screen_x)
            report_mismatch("screen_x", result_o.screen_x, e.screen_x);
          if (result_o.screen_y !== e.screen_y)
            report_mismatch("screen_y", result_o.screen_y, e.screen_y);
          if (result_o.behind_viewer !== e.behind_viewer)
            report_mismatch("behind_viewer", result_o.behind_viewer, e.behind_viewer);
        end
      end
      if (idle_cnt >= WD_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", WD_LIMIT);
        $display("tb_depth_pixel_view_reprojection_unit: errors");
        $finish;
      end
    end
  end

  task automatic write_reg(cfg_reg_e idx, logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      REG_LATERAL_SCALE: sh_scale = val;
      REG_VIEWER_X:      sh_vx = longint'(signed'(val));
      REG_VIEWER_Y:      sh_vy = longint'(signed'(val));
      REG_VIEWER_Z:      sh_vz = longint'(signed'(val));
      REG_YAW_SINE:      sh_ys = longint'(signed'(val[15:0]));
      REG_YAW_COSINE:    sh_yc = longint'(signed'(val[15:0]));
      REG_PITCH_SINE:    sh_ps = longint'(signed'(val[15:0]));
      default:           sh_pc = longint'(signed'(val[15:0]));
    endcase
  endtask

  // one full view setting, written only while the pipeline is empty
  task automatic load_view(logic [31:0] sc, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                           logic [15:0] ys, logic [15:0] yc, logic [15:0] ps, logic [15:0] pc);
    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    write_reg(REG_LATERAL_SCALE, sc);
    write_reg(REG_VIEWER_X, x);
    write_reg(REG_VIEWER_Y, y);
    write_reg(REG_VIEWER_Z, z);
    write_reg(REG_YAW_SINE, {{16{ys[15]}}, ys});
    write_reg(REG_YAW_COSINE, {{16{yc[15]}}, yc});
    write_reg(REG_PITCH_SINE, {{16{ps[15]}}, ps});
    write_reg(REG_PITCH_COSINE, {{16{pc[15]}}, pc});
    cfg_we_i <= 1'b0;
    n_phases++;
  endtask

  task automatic send_pixel(pixel_t p, bit typed, result_t want, bit gaps);
    bit stalled;
    int n;
    if (gaps && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      n = $urandom_range(1, 4);
      repeat (n) @(posedge clk_i);
    end
    start <= 1'b1;
    pixel_i <= p;
    typed_now <= typed;
    typed_now_value <= want;
    forever begin
      @(negedge clk_i);
      stalled = busy;
      @(posedge clk_i);
      if (!stalled) break;
    end
  endtask

  function automatic pixel_t random_pixel();
    pixel_t p;
    p.column = $urandom_range(0, 1023);
    p.row = $urandom_range(0, 1023);
    case ($urandom_range(0, 3))
      0: p.depth_mm = $urandom_range(0, 255);
      1: p.depth_mm = 16'hffff - $urandom_range(0, 255);
      default: p.depth_mm = $urandom;
    endcase
    return p;
  endfunction

  function automatic logic [15:0] random_trig();
    if ($urandom_range(0, 4) == 0) return $urandom;
    return 16'($signed($urandom_range(0, 32768)) - 16384);
  endfunction

  typedef struct {
    pixel_t  pix;
    bit      typed;
    result_t want;
  } row_t;

  row_t directed[$];

  initial begin
    row_t t;
    result_t r;
    pixel_t p;
    int k;
    sh_scale = 0; sh_vx = 0; sh_vy = 0; sh_vz = 0;
    sh_ys = 0; sh_yc = 16384; sh_ps = 0; sh_pc = 16384;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // identity view after reset: only z survives, screen is centered
    t.pix = '{column: 10'd0, row: 10'd0, depth_mm: 16'd0}; t.typed = 1;
    t.want = '{0, 0, 0, 0, 0, 1'b1}; directed.push_back(t);
    t.pix = '{column: 10'd1023, row: 10'd1023, depth_mm: 16'hffff};
    t.want = '{0, 0, 32'sd16776960, 0, 0, 1'b0}; directed.push_back(t);
    t.pix = '{column: 10'd512, row: 10'd384, depth_mm: 16'd1};
    t.want = '{0, 0, 32'sd256, 0, 0, 1'b0}; directed.push_back(t);
    foreach (directed[i]) send_pixel(directed[i].pix, directed[i].typed, directed[i].want, 0);

    // extremes of the view registers, then ordinary ones, checked by the predictor
    for (k = 0; k < 6; k++) begin
      case (k)
        0: load_view(32'hffffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                     16'h4000, 16'hc000, 16'hc000, 16'h4000);
        1: load_view(32'hffffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
                     16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
        2: load_view(32'h00000000, 32'h0, 32'h0, 32'h0, 16'h0, 16'h4000, 16'h0, 16'hc000);
        3: load_view(32'h00010000, 32'h0, 32'h0, 32'h00010000,
                     16'h2d41, 16'h2d41, 16'hf000, 16'h3dbb);
        default: load_view($urandom, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 1<<20),
                           $urandom, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 1<<20),
                           random_trig(), random_trig(), random_trig(), random_trig());
      endcase
      foreach (directed[i]) send_pixel(directed[i].pix, 0, r, 0);
      p = '{column: 10'd0, row: 10'd1023, depth_mm: 16'd1000}; send_pixel(p, 0, r, 0);
      p = '{column: 10'd1023, row: 10'd0, depth_mm: 16'd1000}; send_pixel(p, 0, r, 0);
    end

    // random pixels across several random views, gaps off in every third run of 100 and for the last 200
    for (k = 0; k < N_RANDOM; k++) begin
      if (k % 250 == 0)
        load_view($urandom_range(0, 1) ? $urandom_range(0, 1<<16) : $urandom,
                  $urandom_range(0, 1) ? $urandom_range(0, 1<<18) : $urandom,
                  $urandom_range(0, 1) ? $urandom_range(0, 1<<18) : $urandom,
                  $urandom_range(0, 1) ? $urandom_range(0, 1<<18) : $urandom,
                  random_trig(), random_trig(), random_trig(), random_trig());
      send_pixel(random_pixel(), 0, r, (k < N_RANDOM - 200) && ((k / 100) % 3 != 2));
    end
    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("covered %0d pixels over %0d view settings, %0d results, %0d behind the viewer",
             n_pixels, n_phases, n_results, n_behind);
    $display("mismatches: %0d", n_errors);
    if (n_errors == 0) begin
      $display("tb_depth_pixel_view_reprojection_unit: clean");
    end else begin
      $display("tb_depth_pixel_view_reprojection_unit: errors");
    end
    $finish;
  end

endmodule
